### hdl/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg: shared definitions for the quaternion to Euler angle converter
// Widths, fixed-point constants, the queue word and the CORDIC arctangent
// table used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package qte_pkg;

    // Defaults for the top-level parameters.
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int CORDIC_STAGES_DEF   = 16;

    // Internal widths.
    localparam int PW        = 32;  // one product in Q.28
    localparam int QW        = 36;  // one quadratic form in Q.28
    localparam int XW        = 40;  // CORDIC vector coordinates
    localparam int ZW        = 29;  // CORDIC angle accumulator, Q.24
    localparam int RW        = 58;  // square root remainder and root
    localparam int SQ_STAGES = 29;  // one root bit per stage, 2^56 down to 1
    localparam int RND_W     = 17;  // rounded Q.12 angle before saturation

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int OUT_TDATA_W = 48;

    // Fixed-point constants.
    localparam logic signed [QW-1:0]    ONE_Q28     = 36'sd268435456;
    localparam logic [RW-1:0]           REM_TOP     = 58'd72057594037927936;
    localparam logic signed [ZW-1:0]    PI_Q24      = 29'sd52707179;
    localparam logic signed [13:0]      HALF_PI_Q12 = 14'sd6434;
    localparam logic signed [14:0]      PI_Q12      = 15'sd12868;
    localparam logic signed [RND_W-1:0] HALF_PI_LIM = 17'sd6434;
    localparam logic signed [RND_W-1:0] PI_LIM      = 17'sd12868;

    // One classified item as it waits between the front and the back end.
    typedef struct packed {
        logic signed [QW-1:0] sr;
        logic signed [QW-1:0] cr;
        logic signed [QW-1:0] sy;
        logic signed [QW-1:0] cy;
        logic signed [QW-1:0] sp;
        logic                 clamp;
    } t_item;

    // Arctangent of 2^-i in Q.24.
    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0:    a = 29'sd13176795;
            5'd1:    a = 29'sd7778716;
            5'd2:    a = 29'sd4110060;
            5'd3:    a = 29'sd2086331;
            5'd4:    a = 29'sd1047214;
            5'd5:    a = 29'sd524117;
            5'd6:    a = 29'sd262123;
            5'd7:    a = 29'sd131069;
            5'd8:    a = 29'sd65536;
            5'd9:    a = 29'sd32768;
            5'd10:   a = 29'sd16384;
            5'd11:   a = 29'sd8192;
            5'd12:   a = 29'sd4096;
            5'd13:   a = 29'sd2048;
            5'd14:   a = 29'sd1024;
            5'd15:   a = 29'sd512;
            5'd16:   a = 29'sd256;
            5'd17:   a = 29'sd128;
            5'd18:   a = 29'sd64;
            5'd19:   a = 29'sd32;
            5'd20:   a = 29'sd16;
            5'd21:   a = 29'sd8;
            5'd22:   a = 29'sd4;
            5'd23:   a = 29'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Round a Q.24 angle to Q.12 and saturate it to plus or minus lim.
    function automatic logic signed [RND_W-1:0] round_q12(
        input logic signed [ZW-1:0]    z,
        input logic signed [RND_W-1:0] lim
    );
        logic signed [ZW:0]      t;
        logic signed [RND_W-1:0] r;
        t = (ZW+1)'(z) + (ZW+1)'(2048);
        r = RND_W'(t >>> 12);
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

### hdl/qte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_front: products, quadratic forms and pitch classification
// Two-stage front end. Stage one forms the nine component products in Q.28,
// stage two builds the five quadratic forms and marks a pitch clamp.
// ----------------------------------------------------------------------------
module qte_front import qte_pkg::*; #(
    parameter int CW = COMPONENT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_w,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_item                o_item
);

    localparam int SH = 2 * CW - 32;
    localparam int NP = 9;

    // Product order: wx, yz, xx, yy, wz, xy, zz, wy, zx.
    logic signed [CW-1:0]   a_op [NP];
    logic signed [CW-1:0]   b_op [NP];
    logic signed [2*CW-1:0] prod [NP];
    logic signed [PW-1:0]   q28  [NP];
    logic signed [PW-1:0]   r_prod [NP];
    logic                   r_v1;
    logic                   r_v2;
    t_item                  r_item;
    t_item                  n_item;
    logic                   en;

    // The front end moves whenever its last word can leave.
    assign en      = !r_v2 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v2;
    assign o_item  = r_item;

    always_comb begin
        a_op[0] = i_w; b_op[0] = i_x;
        a_op[1] = i_y; b_op[1] = i_z;
        a_op[2] = i_x; b_op[2] = i_x;
        a_op[3] = i_y; b_op[3] = i_y;
        a_op[4] = i_w; b_op[4] = i_z;
        a_op[5] = i_x; b_op[5] = i_y;
        a_op[6] = i_z; b_op[6] = i_z;
        a_op[7] = i_w; b_op[7] = i_y;
        a_op[8] = i_z; b_op[8] = i_x;
    end

    // Each product is brought to Q.28, with a floor shift when it has more fraction bits.
    for (genvar k = 0; k < NP; k++) begin : g_prod
        assign prod[k] = a_op[k] * b_op[k];
        if (SH >= 0) begin : g_down
            assign q28[k] = PW'(prod[k] >>> SH);
        end else begin : g_up
            assign q28[k] = PW'(prod[k]) <<< (-SH);
        end
    end

    // Quadratic forms and the pitch clamp test.
    always_comb begin
        n_item.sr = (QW'(r_prod[0]) + QW'(r_prod[1])) <<< 1;
        n_item.cr = ONE_Q28 - ((QW'(r_prod[2]) + QW'(r_prod[3])) <<< 1);
        n_item.sy = (QW'(r_prod[4]) + QW'(r_prod[5])) <<< 1;
        n_item.cy = ONE_Q28 - ((QW'(r_prod[3]) + QW'(r_prod[6])) <<< 1);
        n_item.sp = (QW'(r_prod[7]) - QW'(r_prod[8])) <<< 1;
        n_item.clamp = (n_item.sp >= ONE_Q28) || (n_item.sp <= -ONE_Q28);
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= q28;
            r_item <= n_item;
        end
    end

endmodule

### hdl/qte_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_fifo: short queue between the front and the back end
// Holds up to four classified words so that either side can stall on its own.
// ----------------------------------------------------------------------------
module qte_fifo import qte_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[r_wr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue fill count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("empty queue with unequal pointers");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on read");

endmodule

### hdl/qte_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC
// One pre-rotation stage turns a vector with a negative x by pi, then one
// stage per micro-rotation. Returns the vector angle in Q.24, zero for a
// zero vector. The pipe advances only when i_en is high.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [QW-1:0] i_x,
    input  logic signed [QW-1:0] i_y,
    output logic signed [ZW-1:0] o_z
);

    logic signed [XW-1:0] r_x    [STAGES+1];
    logic signed [XW-1:0] r_y    [STAGES+1];
    logic signed [ZW-1:0] r_z    [STAGES+1];
    logic                 r_zero [STAGES+1];
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;

    assign xe = XW'(i_x);
    assign ye = XW'(i_y);

    // Pre-rotation into the right half plane.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -xe;
                r_y[0] <= -ye;
                r_z[0] <= (i_y >= 0) ? PI_Q24 : -PI_Q24;
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_z[0] <= '0;
            end
        end
    end

    // Micro-rotations toward the x axis.
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q24(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q24(5'(i));
                end
            end
        end
    end

    assign o_z = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

### hdl/qte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_back: square root, three CORDIC units and output rounding
// Squares the pitch term, takes the pitch cosine with a one-bit-per-stage
// square root, runs the roll, yaw and pitch CORDIC units side by side and
// rounds into the output register. The whole pipe advances together.
// ----------------------------------------------------------------------------
module qte_back import qte_pkg::*; #(
    parameter int CS = CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [13:0] o_pitch,
    output logic signed [14:0] o_yaw,
    output logic signed [14:0] o_roll,
    output logic              o_clamp
);

    logic                  en;
    logic                  pop;
    logic signed [28:0]    sp_lo;
    logic signed [57:0]    sq;

    // Square root pipe, index 0 holds 2^56 minus the squared term.
    logic [RW-1:0]         r_rem  [SQ_STAGES+1];
    logic [RW-1:0]         r_res  [SQ_STAGES+1];
    logic                  r_sv   [SQ_STAGES+1];
    t_item                 r_si   [SQ_STAGES+1];

    // Side band that follows the CORDIC units.
    logic                  r_cv   [CS+1];
    logic                  r_cc   [CS+1];
    logic                  r_cpos [CS+1];

    logic signed [QW-1:0]  cp;
    logic signed [ZW-1:0]  z_pitch;
    logic signed [ZW-1:0]  z_yaw;
    logic signed [ZW-1:0]  z_roll;
    t_item                 sq_out;

    logic                  r_out_v;
    logic signed [13:0]    r_pitch;
    logic signed [14:0]    r_yaw;
    logic signed [14:0]    r_roll;
    logic                  r_clamp;

    // The pipe moves unless a finished word is held at the output.
    assign en      = !r_out_v || i_ready;
    assign o_ready = en;
    assign pop     = i_valid && en;

    // Only an unclamped pitch term needs the root, and 29 bits hold it.
    assign sp_lo = i_item.sp[28:0];
    assign sq    = sp_lo * sp_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= REM_TOP - $unsigned(sq);
            r_res[0] <= '0;
            r_si[0]  <= i_item;
        end
    end

    // One root bit per stage, trial bit 4^(28-j).
    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STAGES - 1 - j));
        logic [RW-1:0] trial;
        assign trial = r_res[j] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (en) begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_si[j+1] <= r_si[j];
                if (r_rem[j] >= trial) begin
                    r_rem[j+1] <= r_rem[j] - trial;
                    r_res[j+1] <= (r_res[j] >> 1) + BIT;
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_res[j+1] <= r_res[j] >> 1;
                end
            end
        end
    end

    assign sq_out = r_si[SQ_STAGES];
    assign cp     = QW'(r_res[SQ_STAGES]);

    // Angle units.
    qte_cordic #(.STAGES(CS)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (cp),
        .i_y   (sq_out.sp),
        .o_z   (z_pitch)
    );

    qte_cordic #(.STAGES(CS)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (sq_out.cy),
        .i_y   (sq_out.sy),
        .o_z   (z_yaw)
    );

    qte_cordic #(.STAGES(CS)) u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (sq_out.cr),
        .i_y   (sq_out.sr),
        .o_z   (z_roll)
    );

    // Valid and clamp side band beside the CORDIC units.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_sv[SQ_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc[0]   <= sq_out.clamp;
            r_cpos[0] <= (sq_out.sp > 0);
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (en) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cc[i+1]   <= r_cc[i];
                r_cpos[i+1] <= r_cpos[i];
            end
        end
    end

    // Output register: rounding, saturation and the pitch clamp.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_cv[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw   <= 15'(round_q12(z_yaw, PI_LIM));
            r_roll  <= 15'(round_q12(z_roll, PI_LIM));
            r_clamp <= r_cc[CS];
            if (r_cc[CS]) begin
                r_pitch <= r_cpos[CS] ? HALF_PI_Q12 : -HALF_PI_Q12;
            end else begin
                r_pitch <= 14'(round_q12(z_pitch, HALF_PI_LIM));
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_pitch = r_pitch;
    assign o_yaw   = r_yaw;
    assign o_roll  = r_roll;
    assign o_clamp = r_clamp;

    a_clamp_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_clamp) |-> (r_pitch == HALF_PI_Q12 || r_pitch == -HALF_PI_Q12))
        else $error("clamped pitch is not a right angle");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_pitch <= HALF_PI_Q12 && r_pitch >= -HALF_PI_Q12))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_roll <= PI_Q12 && r_roll >= -PI_Q12 &&
                     r_yaw <= PI_Q12 && r_yaw >= -PI_Q12))
        else $error("roll or yaw out of range");

endmodule

### hdl/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Pipeline path from input word to output word:
//   two front stages, one queue slot, one squaring stage, 29 square root stages,
//   CORDIC_STAGES + 1 CORDIC stages and the output register.
// Throughput: one word per cycle while m_axis_tready does not hold the output; every stage is a fully pipelined unit.
// Reset: synchronous, active low; clears all valid flags and the queue.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: unit quaternion to pitch, yaw and roll
// A front end forms the quadratic forms and classifies the pitch clamp, a
// short queue decouples it from the back end, which runs the square root
// and three pipelined CORDIC units and rounds to Q3.12 radians.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // comp_w, comp_x, comp_y, comp_z from the lowest bit up, zero padded
    input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // pitch_angle, yaw_angle, roll_angle from the lowest bit up, zero padded
    output logic [OUT_TDATA_W-1:0]                      m_axis_tdata,
    // pitch_clamped
    output logic [0:0]                                  m_axis_tuser
);

    localparam int CW = COMPONENT_WIDTH;

    logic signed [CW-1:0] comp_w;
    logic signed [CW-1:0] comp_x;
    logic signed [CW-1:0] comp_y;
    logic signed [CW-1:0] comp_z;
    logic                 f_valid;
    logic                 f_ready;
    t_item                f_item;
    logic                 q_valid;
    logic                 q_ready;
    t_item                q_item;
    logic signed [13:0]   pitch_angle;
    logic signed [14:0]   yaw_angle;
    logic signed [14:0]   roll_angle;
    logic                 pitch_clamped;

    // Input word unpacking.
    assign comp_w = s_axis_tdata[CW-1:0];
    assign comp_x = s_axis_tdata[2*CW-1:CW];
    assign comp_y = s_axis_tdata[3*CW-1:2*CW];
    assign comp_z = s_axis_tdata[4*CW-1:3*CW];

    qte_front #(.CW(CW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_w     (comp_w),
        .i_x     (comp_x),
        .i_y     (comp_y),
        .i_z     (comp_z),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    qte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    qte_back #(.CS(CORDIC_STAGES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pitch (pitch_angle),
        .o_yaw   (yaw_angle),
        .o_roll  (roll_angle),
        .o_clamp (pitch_clamped)
    );

    // Output word packing.
    assign m_axis_tdata = {4'b0000, roll_angle, yaw_angle, pitch_angle};
    assign m_axis_tuser = pitch_clamped;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the quaternion to Euler angle converter
// Quaternions are streamed in with random gaps and output stalls; each
// output word is checked against a built-in fixed-point predictor of
// roll, yaw and pitch (square root plus vectoring CORDIC).
// ----------------------------------------------------------------------------
module tb import qte_pkg::*;;

    localparam int CW = 16;
    localparam int NSTAGES = 16;
    localparam longint ONE_Q28_L = 64'sd268435456;
    localparam longint PI_Q24_L = 64'sd52707179;

    typedef struct packed {
        logic signed [13:0] pitch;
        logic signed [14:0] yaw;
        logic signed [14:0] roll;
        logic               clamped;
    } t_angles;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic [63:0] quat_queue[$];
    t_angles     angles_due[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold;
    int          mismatches;

    quaternion_to_euler_angles dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor shift right for signed 64-bit values.
    function automatic longint shr_floor(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint mul_q28(longint a, longint b);
        return a * b;  // Q.28 directly since 2*(CW-2) = 28
    endfunction

    function automatic longint root_floor(longint unsigned r);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > r && bt != 0) bt >>= 2;
        while (bt != 0) begin
            if (r >= res + bt) begin
                r -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC angle of (cx, sy) in Q.24.
    function automatic longint cordic_angle(longint cx, longint sy);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        if (cx == 0 && sy == 0) return 0;
        if (cx < 0) begin
            ang = (sy >= 0) ? PI_Q24_L : -PI_Q24_L;
            cx = -cx;
            sy = -sy;
        end
        for (int i = 0; i < NSTAGES; i++) begin
            dx = shr_floor(sy, i);
            dy = shr_floor(cx, i);
            if (sy < 0) begin
                cx -= dx;
                sy += dy;
                ang -= longint'(atan_q24(5'(i)));
            end else begin
                cx += dx;
                sy -= dy;
                ang += longint'(atan_q24(5'(i)));
            end
        end
        return ang;
    endfunction

    function automatic longint rad_q12(longint ang, longint lim);
        longint r;
        r = shr_floor(ang + 2048, 12);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles euler_of(logic [63:0] q);
        longint w, x, y, z, sr, cr, sy, cy, sp, cp;
        t_angles a;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        sr = 2 * (mul_q28(w, x) + mul_q28(y, z));
        cr = ONE_Q28_L - 2 * (mul_q28(x, x) + mul_q28(y, y));
        sy = 2 * (mul_q28(w, z) + mul_q28(x, y));
        cy = ONE_Q28_L - 2 * (mul_q28(y, y) + mul_q28(z, z));
        sp = 2 * (mul_q28(w, y) - mul_q28(z, x));
        a.roll = 15'(rad_q12(cordic_angle(cr, sr), 12868));
        a.yaw = 15'(rad_q12(cordic_angle(cy, sy), 12868));
        if (sp >= ONE_Q28_L || sp <= -ONE_Q28_L) begin
            a.pitch = (sp > 0) ? 14'sd6434 : -14'sd6434;
            a.clamped = 1'b1;
        end else begin
            cp = root_floor((64'd1 << 56) - longint'(sp * sp));
            a.pitch = 14'(rad_q12(cordic_angle(cp, sp), 6434));
            a.clamped = 1'b0;
        end
        return a;
    endfunction

    function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
        return {16'(z), 16'(y), 16'(x), 16'(w)};
    endfunction

    function automatic int rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 65535) - 32768;  // any raw pattern
        if (r == 1) return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
        return $urandom_range(0, 32768) - 16384;
    endfunction

    // Random rotation with an approximately unit norm.
    function automatic logic [63:0] unit_quat();
        real a, b, c, d, n;
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        d = $urandom_range(0, 2000) - 1000.0;
        if ($urandom_range(0, 7) == 0) begin
            // near gimbal lock
            b = 0.0;
            d = 0.0;
            c = a * (($urandom_range(0, 1) != 0) ? 1.0 : -1.0);
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) return pack_quat(16384, 0, 0, 0);
        return pack_quat($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                         $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
    endfunction

    // Stimulus, pressure phases and the end of the run.
    initial begin
        i_rst_n = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 65;
        recv_hold = 1'b0;
        mismatches = 0;
        // Directed: identity, axis rotations, extremes, gimbal lock, zero.
        quat_queue.push_back(pack_quat(16384, 0, 0, 0));
        quat_queue.push_back(pack_quat(-16384, 0, 0, 0));
        quat_queue.push_back(pack_quat(0, 16384, 0, 0));
        quat_queue.push_back(pack_quat(0, 0, 16384, 0));
        quat_queue.push_back(pack_quat(0, 0, 0, 16384));
        quat_queue.push_back(pack_quat(0, -16384, 0, 0));
        quat_queue.push_back(pack_quat(0, 0, -16384, 0));
        quat_queue.push_back(pack_quat(0, 0, 0, -16384));
        quat_queue.push_back(pack_quat(0, 0, 0, 0));
        quat_queue.push_back(pack_quat(11585, 0, 11585, 0));
        quat_queue.push_back(pack_quat(11585, 0, -11585, 0));
        quat_queue.push_back(pack_quat(11585, 11585, 11585, 11585));
        quat_queue.push_back(pack_quat(11586, 0, 11586, 0));
        quat_queue.push_back(pack_quat(11585, -11585, 0, 0));
        quat_queue.push_back(pack_quat(11585, 0, 0, -11585));
        quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
        quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
        quat_queue.push_back(pack_quat(-32768, 32767, -32768, 32767));
        quat_queue.push_back(pack_quat(8192, 8192, 8192, -8192));
        quat_queue.push_back(pack_quat(16384, 16384, 16384, 16384));
        quat_queue.push_back(pack_quat(1, -1, 1, -1));
        for (int i = 0; i < 600; i++)
            quat_queue.push_back((i % 5 == 4) ?
                pack_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()) : unit_quat());
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (quat_queue.size() == 0);
        // Receiver holds off for a long stretch while words keep coming.
        recv_hold = 1'b1;
        for (int i = 0; i < 100; i++) quat_queue.push_back(unit_quat());
        repeat (300) @(posedge i_clk);
        recv_hold = 1'b0;
        wait (quat_queue.size() == 0);
        // Sender pauses until the pipeline has drained.
        wait (angles_due.size() == 0);
        send_idle_pct = 65;
        recv_idle_pct = 16;
        for (int i = 0; i < 600; i++)
            quat_queue.push_back((i % 5 == 4) ?
                pack_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()) : unit_quat());
        wait (quat_queue.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 550; i++)
            quat_queue.push_back((i % 5 == 4) ?
                pack_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()) : unit_quat());
        wait (quat_queue.size() == 0);
        @(posedge i_clk);
        wait (angles_due.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && angles_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: done, errors");
        $finish;
    end

    // Driver: offers the next quaternion word, idling at random.
    // The word on the bus stays at the head of the queue until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) angles_due.push_back(euler_of(s_axis_tdata));
            if (s_axis_tvalid) void'(quat_queue.pop_front());
            if (quat_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= quat_queue[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        t_angles want;
        t_angles got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[13:0], m_axis_tdata[28:14], m_axis_tdata[43:29],
                       m_axis_tuser[0]};
                if (angles_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("tb: unexpected word %h", got);
                end else begin
                    want = angles_due.pop_front();
                    if (got !== want || m_axis_tdata[47:44] !== 4'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"tb: mismatch pitch %0d/%0d yaw %0d/%0d",
                                      " roll %0d/%0d clamp %0b/%0b"},
                                     want.pitch, got.pitch, want.yaw, got.yaw,
                                     want.roll, got.roll, want.clamped, got.clamped);
                    end
                end
            end
            m_axis_tready <= !recv_hold && $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

endmodule
